// File: rtl/c8alu_pkg.sv
// Shared types and constants for the 8-bit CPU register, ALU and flags unit.
package c8alu_pkg;

	typedef enum logic [5:0] {
		OP_NOP    = 6'd0,
		OP_LDA    = 6'd1,
		OP_LDX    = 6'd2,
		OP_LDY    = 6'd3,
		OP_STA    = 6'd4,
		OP_STX    = 6'd5,
		OP_STY    = 6'd6,
		OP_TAX    = 6'd7,
		OP_TAY    = 6'd8,
		OP_TSX    = 6'd9,
		OP_TXA    = 6'd10,
		OP_TXS    = 6'd11,
		OP_TYA    = 6'd12,
		OP_PHA    = 6'd13,
		OP_PHP    = 6'd14,
		OP_PLA    = 6'd15,
		OP_PLP    = 6'd16,
		OP_DEC    = 6'd17,
		OP_DEX    = 6'd18,
		OP_DEY    = 6'd19,
		OP_INC    = 6'd20,
		OP_INX    = 6'd21,
		OP_INY    = 6'd22,
		OP_ADC    = 6'd23,
		OP_SBC    = 6'd24,
		OP_AND    = 6'd25,
		OP_EOR    = 6'd26,
		OP_ORA    = 6'd27,
		OP_ASL_A  = 6'd28,
		OP_LSR_A  = 6'd29,
		OP_ROL_A  = 6'd30,
		OP_ROR_A  = 6'd31,
		OP_ASL_M  = 6'd32,
		OP_LSR_M  = 6'd33,
		OP_ROL_M  = 6'd34,
		OP_ROR_M  = 6'd35,
		OP_CLC    = 6'd36,
		OP_SEC    = 6'd37,
		OP_CLI    = 6'd38,
		OP_SEI    = 6'd39,
		OP_CLV    = 6'd40,
		OP_CMP    = 6'd41,
		OP_CPX    = 6'd42,
		OP_CPY    = 6'd43,
		OP_BIT    = 6'd44,
		OP_BRANCH = 6'd45
	} op_t;

	typedef enum logic [2:0] {
		BR_CC = 3'd0,
		BR_CS = 3'd1,
		BR_EQ = 3'd2,
		BR_MI = 3'd3,
		BR_NE = 3'd4,
		BR_PL = 3'd5,
		BR_VC = 3'd6,
		BR_VS = 3'd7
	} br_cond_t;

	typedef enum logic [1:0] {
		SH_ASL = 2'd0,
		SH_LSR = 2'd1,
		SH_ROL = 2'd2,
		SH_ROR = 2'd3
	} shift_kind_t;

	// status bit positions
	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_Z = 1;
	localparam int unsigned FL_I = 2;
	localparam int unsigned FL_V = 6;
	localparam int unsigned FL_N = 7;

	localparam logic [7:0] ACC_RESET   = 8'h00;
	localparam logic [7:0] IDX_RESET   = 8'h00;
	localparam logic [7:0] SP_RESET    = 8'hFD;
	localparam logic [7:0] FLAGS_RESET = 8'h04;
	localparam logic [7:0] PUSH_SET    = 8'h30;
	localparam logic [7:0] STATUS_MASK = 8'hCF;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] flags;
	} arch_state_t;

	typedef struct packed {
		logic [7:0] store_byte;
		logic       taken;
		logic       fault;
	} exec_res_t;

endpackage

// File: rtl/c8alu_exec.sv
// Combinational execute logic: next register state and result for one operation.
module c8alu_exec import c8alu_pkg::*; (
	input  logic [5:0]  mode,
	input  logic [7:0]  operand,
	input  logic [2:0]  branch_cond,
	input  arch_state_t cur,
	output arch_state_t nxt,
	output exec_res_t   res
);

	logic [8:0]  add_sum;
	logic [8:0]  sub_diff;
	logic [8:0]  cmp_diff;
	logic [7:0]  cmp_reg;
	logic [7:0]  sh_src;
	logic [7:0]  sh_out;
	logic        sh_cout;
	logic [7:0]  nz_val;
	logic        nz_en;
	logic        cin;
	op_t         op;

	assign op  = op_t'(mode);
	assign cin = cur.flags[FL_C];

	assign add_sum  = {1'b0, cur.acc} + {1'b0, operand} + {8'b0, cin};
	// borrow out shows in bit 8; carry is its inverse
	assign sub_diff = {1'b0, cur.acc} - {1'b0, operand} - {8'b0, ~cin};

	always_comb begin
		case (op)
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = cur.acc;
		endcase
	end
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

	// memory-form shifts sit at codes 32..35, accumulator form at 28..31
	assign sh_src = mode[5] ? operand : cur.acc;

	always_comb begin
		case (shift_kind_t'(mode[1:0]))
			SH_ASL: begin
				sh_out  = {sh_src[6:0], 1'b0};
				sh_cout = sh_src[7];
			end
			SH_LSR: begin
				sh_out  = {1'b0, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
			SH_ROL: begin
				sh_out  = {sh_src[6:0], cin};
				sh_cout = sh_src[7];
			end
			SH_ROR: begin
				sh_out  = {cin, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
			default: begin
				sh_out  = sh_src;
				sh_cout = cin;
			end
		endcase
	end

	always_comb begin
		nxt            = cur;
		res.store_byte = 8'h00;
		res.taken      = 1'b0;
		res.fault      = 1'b0;
		nz_val         = 8'h00;
		nz_en          = 1'b0;
		case (op)
			OP_NOP: ;
			OP_LDA: begin nxt.acc = operand; nz_val = operand; nz_en = 1'b1; end
			OP_LDX: begin nxt.x = operand; nz_val = operand; nz_en = 1'b1; end
			OP_LDY: begin nxt.y = operand; nz_val = operand; nz_en = 1'b1; end
			OP_STA: res.store_byte = cur.acc;
			OP_STX: res.store_byte = cur.x;
			OP_STY: res.store_byte = cur.y;
			OP_TAX: begin nxt.x = cur.acc; nz_val = cur.acc; nz_en = 1'b1; end
			OP_TAY: begin nxt.y = cur.acc; nz_val = cur.acc; nz_en = 1'b1; end
			OP_TSX: begin nxt.x = cur.sp; nz_val = cur.sp; nz_en = 1'b1; end
			OP_TXA: begin nxt.acc = cur.x; nz_val = cur.x; nz_en = 1'b1; end
			OP_TXS: nxt.sp = cur.x;
			OP_TYA: begin nxt.acc = cur.y; nz_val = cur.y; nz_en = 1'b1; end
			OP_PHA: begin
				res.store_byte = cur.acc;
				nxt.sp         = cur.sp - 8'd1;
			end
			OP_PHP: begin
				res.store_byte = cur.flags | PUSH_SET;
				nxt.sp         = cur.sp - 8'd1;
			end
			OP_PLA: begin
				nxt.sp  = cur.sp + 8'd1;
				nxt.acc = operand;
				nz_val  = operand;
				nz_en   = 1'b1;
			end
			OP_PLP: begin
				nxt.sp    = cur.sp + 8'd1;
				nxt.flags = operand & STATUS_MASK;
			end
			OP_DEC: begin
				res.store_byte = operand - 8'd1;
				nz_val         = operand - 8'd1;
				nz_en          = 1'b1;
			end
			OP_DEX: begin nxt.x = cur.x - 8'd1; nz_val = cur.x - 8'd1; nz_en = 1'b1; end
			OP_DEY: begin nxt.y = cur.y - 8'd1; nz_val = cur.y - 8'd1; nz_en = 1'b1; end
			OP_INC: begin
				res.store_byte = operand + 8'd1;
				nz_val         = operand + 8'd1;
				nz_en          = 1'b1;
			end
			OP_INX: begin nxt.x = cur.x + 8'd1; nz_val = cur.x + 8'd1; nz_en = 1'b1; end
			OP_INY: begin nxt.y = cur.y + 8'd1; nz_val = cur.y + 8'd1; nz_en = 1'b1; end
			OP_ADC: begin
				nxt.acc         = add_sum[7:0];
				nxt.flags[FL_C] = add_sum[8];
				nxt.flags[FL_V] = ~(cur.acc[7] ^ operand[7]) & (cur.acc[7] ^ add_sum[7]);
				nz_val          = add_sum[7:0];
				nz_en           = 1'b1;
			end
			OP_SBC: begin
				nxt.acc         = sub_diff[7:0];
				nxt.flags[FL_C] = ~sub_diff[8];
				nxt.flags[FL_V] = (cur.acc[7] ^ sub_diff[7]) & (cur.acc[7] ^ operand[7]);
				nz_val          = sub_diff[7:0];
				nz_en           = 1'b1;
			end
			OP_AND: begin
				nxt.acc = cur.acc & operand; nz_val = cur.acc & operand; nz_en = 1'b1;
			end
			OP_EOR: begin
				nxt.acc = cur.acc ^ operand; nz_val = cur.acc ^ operand; nz_en = 1'b1;
			end
			OP_ORA: begin
				nxt.acc = cur.acc | operand; nz_val = cur.acc | operand; nz_en = 1'b1;
			end
			OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
				nxt.acc         = sh_out;
				nxt.flags[FL_C] = sh_cout;
				nz_val          = sh_out;
				nz_en           = 1'b1;
			end
			OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
				res.store_byte  = sh_out;
				nxt.flags[FL_C] = sh_cout;
				nz_val          = sh_out;
				nz_en           = 1'b1;
			end
			OP_CLC: nxt.flags[FL_C] = 1'b0;
			OP_SEC: nxt.flags[FL_C] = 1'b1;
			OP_CLI: nxt.flags[FL_I] = 1'b0;
			OP_SEI: nxt.flags[FL_I] = 1'b1;
			OP_CLV: nxt.flags[FL_V] = 1'b0;
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.flags[FL_C] = ~cmp_diff[8];
				nz_val          = cmp_diff[7:0];
				nz_en           = 1'b1;
			end
			OP_BIT: begin
				nxt.flags[FL_Z] = ((cur.acc & operand) == 8'h00);
				nxt.flags[FL_V] = operand[6];
				nxt.flags[FL_N] = operand[7];
			end
			OP_BRANCH: begin
				case (br_cond_t'(branch_cond))
					BR_CC:   res.taken = ~cur.flags[FL_C];
					BR_CS:   res.taken = cur.flags[FL_C];
					BR_EQ:   res.taken = cur.flags[FL_Z];
					BR_MI:   res.taken = cur.flags[FL_N];
					BR_NE:   res.taken = ~cur.flags[FL_Z];
					BR_PL:   res.taken = ~cur.flags[FL_N];
					BR_VC:   res.taken = ~cur.flags[FL_V];
					BR_VS:   res.taken = cur.flags[FL_V];
					default: res.taken = 1'b0;
				endcase
			end
			default: res.fault = 1'b1;
		endcase
		if (nz_en) begin
			nxt.flags[FL_Z] = (nz_val == 8'h00);
			nxt.flags[FL_N] = nz_val[7];
		end
	end

endmodule

// File: rtl/cpu8_register_alu_flags_unit.sv
// Top level: input register, execute logic, architectural registers and result register.
// A word in the input register moves into the result register when that register is free.
// Throughput: one word per cycle unless out_stall holds the result; register and flag
// feedback closes through the execute logic between input and architectural registers.
// Reset: asynchronous, active low; clears valid state, sets A, X, Y to 0,
// the stack pointer to 0xFD and the status to interrupt disable only.
module cpu8_register_alu_flags_unit import c8alu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [5:0] mode,
	input  logic [7:0] operand,
	input  logic [2:0] branch_cond,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] store_byte,
	output logic [7:0] accumulator,
	output logic [7:0] index_x,
	output logic [7:0] index_y,
	output logic [7:0] stack_pointer,
	output logic [7:0] status_flags,
	output logic       branch_taken,
	output logic       illegal_fault
);

	logic        valid_s1;
	logic [5:0]  mode_s1;
	logic [7:0]  operand_s1;
	logic [2:0]  cond_s1;
	arch_state_t state_q;
	arch_state_t state_nxt;
	exec_res_t   exec_res;
	logic        out_free;
	logic        advance;
	logic        in_take;

	logic [7:0]  store_q;
	arch_state_t regs_out_q;
	logic        taken_q;
	logic        fault_q;

	assign out_free = ~out_valid | ~out_stall;
	assign advance  = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;
	assign in_take  = in_valid & ~in_stall;

	c8alu_exec u_exec (
		.mode        (mode_s1),
		.operand     (operand_s1),
		.branch_cond (cond_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (exec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1    <= mode;
			operand_s1 <= operand;
			cond_s1    <= branch_cond;
		end
	end

	// architectural registers commit as the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.acc   <= ACC_RESET;
			state_q.x     <= IDX_RESET;
			state_q.y     <= IDX_RESET;
			state_q.sp    <= SP_RESET;
			state_q.flags <= FLAGS_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			store_q    <= exec_res.store_byte;
			regs_out_q <= state_nxt;
			taken_q    <= exec_res.taken;
			fault_q    <= exec_res.fault;
		end
	end

	assign store_byte    = store_q;
	assign accumulator   = regs_out_q.acc;
	assign index_x       = regs_out_q.x;
	assign index_y       = regs_out_q.y;
	assign stack_pointer = regs_out_q.sp;
	assign status_flags  = regs_out_q.flags & STATUS_MASK;
	assign branch_taken  = taken_q;
	assign illegal_fault = fault_q;

endmodule
